>>> hw/rtl/iitg_pkg.sv
// Shared types and constants of the instance interval trace gate.
// Used by iitg_ctrl, iitg_datapath and instance_interval_trace_gate; no dependencies.
package iitg_pkg;

   localparam int CMD_W   = 2;
   localparam int SLOT_W  = 4;
   localparam int INST_W  = 32;
   localparam int CSR_W   = 5;
   localparam int CSR_IDX_W = 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENTER = 2'd0,
      CMD_EXIT  = 2'd1,
      CMD_WRITE = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_REGION_SELECTED = 1'd0,
      REG_INTERVAL_COUNT  = 1'd1
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CHECK,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic advance;
      logic load;
      logic retire;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rsp_free;
      logic final_exit;
      logic past_last;
      logic can_advance;
   } ctrl_status_type;

endpackage

>>> hw/rtl/iitg_ctrl.sv
// Sequencing state machine of the instance interval trace gate.
// Depends on iitg_pkg; drives the command struct of iitg_datapath.
module iitg_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  iitg_pkg::ctrl_status_type status,
   output iitg_pkg::ctrl_cmd_type    ctrl
);

   iitg_pkg::state_type state_ff;
   iitg_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iitg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         iitg_pkg::ST_IDLE: begin
            if (req_valid && status.rsp_free) state_in = iitg_pkg::ST_EXEC;
         end
         iitg_pkg::ST_EXEC: begin
            state_in = status.final_exit ? iitg_pkg::ST_CHECK : iitg_pkg::ST_IDLE;
         end
         iitg_pkg::ST_CHECK: begin
            if (status.past_last && status.can_advance) state_in = iitg_pkg::ST_LOAD;
            else state_in = iitg_pkg::ST_IDLE;
         end
         iitg_pkg::ST_LOAD: begin
            state_in = iitg_pkg::ST_CHECK;
         end
         default: begin
            state_in = iitg_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall    = 1'b1;
      ctrl         = '0;
      unique case (state_ff)
         iitg_pkg::ST_IDLE: begin
            req_stall    = !status.rsp_free;
            ctrl.capture = req_valid && status.rsp_free;
         end
         iitg_pkg::ST_EXEC: begin
            ctrl.execute = 1'b1;
         end
         iitg_pkg::ST_CHECK: begin
            ctrl.advance = status.past_last && status.can_advance;
            ctrl.retire  = status.past_last && !status.can_advance;
         end
         iitg_pkg::ST_LOAD: begin
            ctrl.load = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // table loads only follow a check
   assert property (@(posedge clock) disable iff (reset)
      state_ff == iitg_pkg::ST_LOAD |-> $past(state_ff) == iitg_pkg::ST_CHECK)
      else $error("load without preceding check");

   // the walk starts only from an executed exit or a load
   assert property (@(posedge clock) disable iff (reset)
      state_ff == iitg_pkg::ST_CHECK |->
         ($past(state_ff) == iitg_pkg::ST_EXEC || $past(state_ff) == iitg_pkg::ST_LOAD))
      else $error("check entered from wrong state");

   // request beats are held off outside the idle state
   assert property (@(posedge clock) disable iff (reset)
      state_ff != iitg_pkg::ST_IDLE |-> req_stall)
      else $error("request beat taken while busy");

endmodule

>>> hw/rtl/iitg_datapath.sv
// Datapath of the instance interval trace gate: counters, interval table, result register.
// Depends on iitg_pkg; commanded by iitg_ctrl.
module iitg_datapath #(
   parameter int MAX_INTERVALS = 16,
   parameter int COUNT_WIDTH   = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [iitg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [iitg_pkg::CSR_W-1:0]         csr_write_data,
   input  logic [iitg_pkg::CMD_W-1:0]         req_cmd,
   input  logic                               req_recording_on,
   input  logic                               req_enable_granted,
   input  logic [iitg_pkg::SLOT_W-1:0]        req_slot,
   input  logic [iitg_pkg::INST_W-1:0]        req_first_instance,
   input  logic [iitg_pkg::INST_W-1:0]        req_last_instance,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_answer,
   output logic                               rsp_enable_request,
   output logic                               rsp_disable_request,
   input  iitg_pkg::ctrl_cmd_type             ctrl,
   output iitg_pkg::ctrl_status_type          status
);

   localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int NW    = IDX_W + 1;
   localparam int XW    = (COUNT_WIDTH > iitg_pkg::INST_W) ? COUNT_WIDTH : iitg_pkg::INST_W;
   localparam int IW    = iitg_pkg::INST_W;

   // configuration
   logic                             region_selected_ff, region_selected_in;
   logic [iitg_pkg::CSR_W-1:0]       interval_count_ff, interval_count_in;

   // captured item
   iitg_pkg::cmd_type                cmd_ff;
   logic                             rec_ff;
   logic                             granted_ff;
   logic [iitg_pkg::SLOT_W-1:0]      slot_ff;
   logic [IW-1:0]                    first_ff;
   logic [IW-1:0]                    last_ff;

   // gate state
   logic [COUNT_WIDTH-1:0]           enter_count_ff, enter_count_in;
   logic [COUNT_WIDTH-1:0]           depth_ff, depth_in;
   logic                             owns_ff, owns_in;
   logic [IDX_W-1:0]                 index_ff, index_in;
   logic [IW-1:0]                    cur_first_ff, cur_first_in;
   logic [IW-1:0]                    cur_last_ff, cur_last_in;
   logic                             live_ff, live_in;

   // result register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             answer_ff, answer_in;
   logic                             en_ff, en_in;
   logic                             dis_ff, dis_in;

   // interval table
   logic [2*IW-1:0]                  table_mem [MAX_INTERVALS];
   logic [2*IW-1:0]                  rd_data_ff;
   logic [IDX_W-1:0]                 rd_addr;
   logic [IDX_W-1:0]                 slot_idx;
   logic                             slot_ok;
   logic                             slot_is_current;
   logic [NW-1:0]                    used_n;
   logic                             in_interval;
   logic                             table_write;

   always_comb begin
      if (interval_count_ff == '0) used_n = NW'(1);
      else if (32'(interval_count_ff) > MAX_INTERVALS) used_n = NW'(MAX_INTERVALS);
      else used_n = NW'(interval_count_ff);
   end

   assign slot_ok         = 32'(slot_ff) < MAX_INTERVALS;
   assign slot_idx        = IDX_W'(slot_ff);
   assign slot_is_current = 32'(slot_ff) == 32'(index_ff);
   assign in_interval     = (XW'(enter_count_ff) >= XW'(cur_first_ff))
                         && (XW'(enter_count_ff) <= XW'(cur_last_ff));
   assign table_write     = ctrl.execute && (cmd_ff == iitg_pkg::CMD_WRITE) && slot_ok;

   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign status.final_exit  = (cmd_ff == iitg_pkg::CMD_EXIT) && owns_ff
                            && !(depth_ff > COUNT_WIDTH'(1));
   assign status.past_last   = XW'(cur_last_ff) < XW'(enter_count_ff);
   assign status.can_advance = (NW'(index_ff) + NW'(1)) < used_n;

   assign rd_addr = status.can_advance ? index_ff + IDX_W'(1) : index_ff;

   always_ff @(posedge clock) begin
      if (table_write) table_mem[slot_idx] <= {last_ff, first_ff};
      rd_data_ff <= table_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff     <= iitg_pkg::cmd_type'(req_cmd);
         rec_ff     <= req_recording_on;
         granted_ff <= req_enable_granted;
         slot_ff    <= req_slot;
         first_ff   <= req_first_instance;
         last_ff    <= req_last_instance;
      end
   end

   always_comb begin
      region_selected_in = region_selected_ff;
      interval_count_in  = interval_count_ff;
      if (csr_write_enable) begin
         unique case (iitg_pkg::csr_reg_type'(csr_index))
            iitg_pkg::REG_REGION_SELECTED: region_selected_in = csr_write_data[0];
            iitg_pkg::REG_INTERVAL_COUNT:  interval_count_in  = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      enter_count_in = enter_count_ff;
      depth_in       = depth_ff;
      owns_in        = owns_ff;
      index_in       = index_ff;
      cur_first_in   = cur_first_ff;
      cur_last_in    = cur_last_ff;
      live_in        = live_ff;
      rsp_valid_in   = rsp_valid_ff;
      answer_in      = answer_ff;
      en_in          = en_ff;
      dis_in         = dis_ff;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      if (ctrl.execute) begin
         rsp_valid_in = 1'b1;
         answer_in    = 1'b0;
         en_in        = 1'b0;
         dis_in       = 1'b0;
         case (cmd_ff)
            iitg_pkg::CMD_ENTER: begin
               if (!(region_selected_ff && live_ff)) begin
                  answer_in = rec_ff;
               end else if (owns_ff) begin
                  enter_count_in = enter_count_ff + COUNT_WIDTH'(1);
                  depth_in       = depth_ff + COUNT_WIDTH'(1);
                  answer_in      = 1'b1;
               end else if (rec_ff) begin
                  enter_count_in = enter_count_ff + COUNT_WIDTH'(1);
                  answer_in      = 1'b1;
               end else if (in_interval) begin
                  en_in = 1'b1;
                  if (granted_ff) begin
                     enter_count_in = enter_count_ff + COUNT_WIDTH'(1);
                     depth_in       = COUNT_WIDTH'(1);
                     owns_in        = 1'b1;
                     answer_in      = 1'b1;
                  end
               end else begin
                  enter_count_in = enter_count_ff + COUNT_WIDTH'(1);
               end
            end
            iitg_pkg::CMD_EXIT: begin
               if (owns_ff) begin
                  answer_in = 1'b1;
                  if (depth_ff > COUNT_WIDTH'(1)) begin
                     depth_in = depth_ff - COUNT_WIDTH'(1);
                  end else begin
                     depth_in = '0;
                     dis_in   = 1'b1;
                     owns_in  = 1'b0;
                  end
               end else begin
                  answer_in = rec_ff;
               end
            end
            iitg_pkg::CMD_WRITE: begin
               if (slot_ok && slot_is_current) begin
                  cur_first_in = first_ff;
                  cur_last_in  = last_ff;
               end
            end
            default: ;
         endcase
      end

      if (ctrl.advance) index_in = index_ff + IDX_W'(1);
      if (ctrl.load) begin
         cur_first_in = rd_data_ff[IW-1:0];
         cur_last_in  = rd_data_ff[2*IW-1:IW];
      end
      if (ctrl.retire) live_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_selected_ff <= 1'b0;
         interval_count_ff  <= iitg_pkg::CSR_W'(1);
         enter_count_ff     <= '0;
         depth_ff           <= '0;
         owns_ff            <= 1'b0;
         index_ff           <= '0;
         cur_first_ff       <= '0;
         cur_last_ff        <= '0;
         live_ff            <= 1'b1;
         rsp_valid_ff       <= 1'b0;
      end else begin
         region_selected_ff <= region_selected_in;
         interval_count_ff  <= interval_count_in;
         enter_count_ff     <= enter_count_in;
         depth_ff           <= depth_in;
         owns_ff            <= owns_in;
         index_ff           <= index_in;
         cur_first_ff       <= cur_first_in;
         cur_last_ff        <= cur_last_in;
         live_ff            <= live_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      answer_ff <= answer_in;
      en_ff     <= en_in;
      dis_ff    <= dis_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_answer          = answer_ff;
   assign rsp_enable_request  = en_ff;
   assign rsp_disable_request = dis_ff;

   // an exhausted selection never comes back
   assert property (@(posedge clock) disable iff (reset)
      !live_ff |=> !live_ff)
      else $error("selection revived");

   // ownership is only taken with a live selection and dropped before it dies
   assert property (@(posedge clock) disable iff (reset)
      owns_ff |-> live_ff)
      else $error("owning recording without live selection");

   // an item only executes into an empty result register
   assert property (@(posedge clock) disable iff (reset)
      ctrl.execute |-> !rsp_valid_ff)
      else $error("result register overwritten");

endmodule

>>> hw/rtl/instance_interval_trace_gate.sv
// Instance interval trace gate: decides per enter/exit beat whether a region is recorded,
// selecting enter instances by a loaded table of intervals first..last.
// A request beat is taken one cycle and executed the next, where enters, writes and inner
// exits end. An exit that releases recording then walks the interval table, alternating a
// check and a load per skipped interval, through the single read port of the table memory,
// and skips at most MAX_INTERVALS-1 intervals. The result sits in a single output register;
// while it waits the next request beat is held off, and it is taken at the earliest in the
// cycle that the waiting result is taken.
// Configuration writes take effect at the next clock edge; no clearing pass after reset.
module instance_interval_trace_gate #(
   parameter int MAX_INTERVALS = 16,
   parameter int COUNT_WIDTH   = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [iitg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [iitg_pkg::CSR_W-1:0]         csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [iitg_pkg::CMD_W-1:0]         req_cmd,
   input  logic                               req_recording_on,
   input  logic                               req_enable_granted,
   input  logic [iitg_pkg::SLOT_W-1:0]        req_slot,
   input  logic [iitg_pkg::INST_W-1:0]        req_first_instance,
   input  logic [iitg_pkg::INST_W-1:0]        req_last_instance,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_answer,
   output logic                               rsp_enable_request,
   output logic                               rsp_disable_request
);

   iitg_pkg::ctrl_cmd_type    ctrl;
   iitg_pkg::ctrl_status_type status;

   iitg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   iitg_datapath #(
      .MAX_INTERVALS (MAX_INTERVALS),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_cmd             (req_cmd),
      .req_recording_on    (req_recording_on),
      .req_enable_granted  (req_enable_granted),
      .req_slot            (req_slot),
      .req_first_instance  (req_first_instance),
      .req_last_instance   (req_last_instance),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_answer          (rsp_answer),
      .rsp_enable_request  (rsp_enable_request),
      .rsp_disable_request (rsp_disable_request),
      .ctrl                (ctrl),
      .status              (status)
   );

endmodule
